// ===== hw/rtl/qcsv_pkg.sv =====
// Package for the quoted CSV field splitter.
// Holds the item and result types, character and result codes, and sizing constants.
// No dependencies.
package qcsv_pkg;

  localparam int MAX_FIELDS = 32;
  localparam int CNT_W      = $clog2(MAX_FIELDS + 1);
  localparam int LIMIT_W    = 6;
  localparam int IDX_W      = 5;
  localparam int CMP_W      = (CNT_W > LIMIT_W) ? CNT_W : LIMIT_W;
  localparam int IDX_MAX    = (1 << IDX_W) - 1;

  localparam logic [LIMIT_W-1:0] FIELD_LIMIT_RESET = LIMIT_W'(32);

  localparam logic [7:0] QUOTE_CH = 8'h22;
  localparam logic [7:0] COMMA_CH = 8'h2C;

  localparam logic KIND_CHAR = 1'b0;
  localparam logic KIND_END  = 1'b1;

  localparam logic [1:0] RK_VALUE = 2'd0;
  localparam logic [1:0] RK_END   = 2'd1;
  localparam logic [1:0] RK_ERROR = 2'd2;

  localparam logic [1:0] ERR_TOO_MANY  = 2'd0;
  localparam logic [1:0] ERR_STRAY_QT  = 2'd1;
  localparam logic [1:0] ERR_UNCLOSED  = 2'd2;
  localparam logic [1:0] ERR_JUNK_QT   = 2'd3;

  typedef struct packed {
    logic       kind;
    logic [7:0] char_byte;
  } qcsv_item_t;

  typedef struct packed {
    logic [1:0]       result_kind;
    logic [7:0]       value_byte;
    logic [IDX_W-1:0] field_index;
    logic [1:0]       error_code;
    logic             last;
  } qcsv_result_t;

endpackage

// ===== hw/rtl/qcsv_if.sv =====
// Channel interfaces for the quoted CSV field splitter.
// The input channel carries record bytes, the output channel carries results.
// Depends on qcsv_pkg.
interface qcsv_in_if
  import qcsv_pkg::*;
;
  logic       valid;
  logic       ready;
  logic       kind;
  logic [7:0] char_byte;

  modport source (output valid, output kind, output char_byte, input ready);
  modport sink (input valid, input kind, input char_byte, output ready);
endinterface

interface qcsv_out_if
  import qcsv_pkg::*;
;
  logic             valid;
  logic             ready;
  logic [1:0]       result_kind;
  logic [7:0]       value_byte;
  logic [IDX_W-1:0] field_index;
  logic [1:0]       error_code;
  logic             last;

  modport source (output valid, output result_kind, output value_byte,
                  output field_index, output error_code, output last, input ready);
  modport sink (input valid, input result_kind, input value_byte,
                input field_index, input error_code, input last, output ready);
endinterface

// ===== hw/rtl/qcsv_parser.sv =====
// Input register, field limit register and record parsing state machine.
// Produces at most one result per transfer toward the output buffer.
// Depends on qcsv_pkg.
module qcsv_parser
  import qcsv_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cfg_we,
  input  logic [LIMIT_W-1:0] cfg_wdata,
  input  logic               in_valid,
  output logic               in_ready,
  input  qcsv_item_t         in_item,
  input  logic               res_ready,
  output logic               res_valid,
  output qcsv_result_t       res
);

  typedef enum logic [2:0] {
    PH_START,
    PH_PLAIN,
    PH_QUOTED,
    PH_QSEEN,
    PH_SWALLOW
  } phase_t;

  phase_t             phase_r, phase_nxt;
  logic [CNT_W-1:0]   cnt_r, cnt_nxt;
  logic [LIMIT_W-1:0] field_limit_r;
  logic               s1_valid_r;
  qcsv_item_t         s1_item_r;
  logic               s1_go;

  logic               at_end;
  logic               is_quote;
  logic               is_comma;
  logic [CMP_W-1:0]   limit;
  logic               at_limit;
  logic               do_fail;
  logic [1:0]         fail_code;
  logic               do_end;
  logic               do_value;
  logic [7:0]         value;
  logic               do_restart;

  assign s1_go    = s1_valid_r && res_ready;
  assign in_ready = !s1_valid_r || s1_go;

  assign at_end   = (s1_item_r.kind == KIND_END);
  assign is_quote = (s1_item_r.char_byte == QUOTE_CH);
  assign is_comma = (s1_item_r.char_byte == COMMA_CH);
  assign limit    = (CMP_W'(field_limit_r) > CMP_W'(MAX_FIELDS)) ?
                    CMP_W'(MAX_FIELDS) : CMP_W'(field_limit_r);
  assign at_limit = (CMP_W'(cnt_r) >= limit);

  always_comb begin
    do_fail    = 1'b0;
    fail_code  = ERR_TOO_MANY;
    do_end     = 1'b0;
    do_value   = 1'b0;
    value      = s1_item_r.char_byte;
    do_restart = 1'b0;
    phase_nxt  = phase_r;
    unique case (phase_r)
      PH_START: begin
        if (at_limit) begin
          do_fail = 1'b1;
        end else if (at_end || is_comma) begin
          do_end = 1'b1;
        end else if (is_quote) begin
          phase_nxt = PH_QUOTED;
        end else begin
          do_value  = 1'b1;
          phase_nxt = PH_PLAIN;
        end
      end
      PH_PLAIN: begin
        if (at_end || is_comma) begin
          do_end = 1'b1;
        end else if (is_quote) begin
          do_fail   = 1'b1;
          fail_code = ERR_STRAY_QT;
        end else begin
          do_value = 1'b1;
        end
      end
      PH_QUOTED: begin
        if (at_end) begin
          do_fail   = 1'b1;
          fail_code = ERR_UNCLOSED;
        end else if (is_quote) begin
          phase_nxt = PH_QSEEN;
        end else begin
          do_value = 1'b1;
        end
      end
      PH_QSEEN: begin
        if (at_end || is_comma) begin
          do_end = 1'b1;
        end else if (is_quote) begin
          do_value  = 1'b1;
          value     = QUOTE_CH;
          phase_nxt = PH_QUOTED;
        end else begin
          do_fail   = 1'b1;
          fail_code = ERR_JUNK_QT;
        end
      end
      default: begin
        do_restart = at_end;
      end
    endcase

    cnt_nxt = cnt_r;
    if (do_fail) begin
      phase_nxt  = PH_SWALLOW;
      do_restart = at_end;
    end
    if (do_end) begin
      phase_nxt = PH_START;
      if (at_end) begin
        do_restart = 1'b1;
      end else if (CMP_W'(cnt_r) < CMP_W'(MAX_FIELDS)) begin
        cnt_nxt = cnt_r + CNT_W'(1);
      end
    end
    if (do_restart) begin
      phase_nxt = PH_START;
      cnt_nxt   = '0;
    end
  end

  always_comb begin
    res.result_kind = do_fail ? RK_ERROR : (do_end ? RK_END : RK_VALUE);
    res.value_byte  = do_value ? value : 8'h00;
    res.field_index = (CMP_W'(cnt_r) > CMP_W'(IDX_MAX)) ? IDX_W'(IDX_MAX) : IDX_W'(cnt_r);
    res.error_code  = do_fail ? fail_code : ERR_TOO_MANY;
    res.last        = do_fail || (do_end && at_end);
  end

  assign res_valid = s1_go && (do_fail || do_end || do_value);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r    <= 1'b0;
      phase_r       <= PH_START;
      cnt_r         <= '0;
      field_limit_r <= FIELD_LIMIT_RESET;
    end else begin
      if (in_ready) begin
        s1_valid_r <= in_valid;
      end
      if (s1_go) begin
        phase_r <= phase_nxt;
        cnt_r   <= cnt_nxt;
      end
      if (cfg_we) begin
        field_limit_r <= cfg_wdata;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_item_r <= in_item;
    end
  end

endmodule

// ===== hw/rtl/qcsv_out_buf.sv =====
// Two-entry output buffer: a result register backed by a skid register.
// Its ready comes from a register, so the receiver's ready never reaches the input side.
// Depends on qcsv_pkg.
module qcsv_out_buf
  import qcsv_pkg::*;
(
  input  logic         clk,
  input  logic         rst_n,
  input  logic         push_valid,
  output logic         push_ready,
  input  qcsv_result_t push_data,
  output logic         pop_valid,
  input  logic         pop_ready,
  output qcsv_result_t pop_data
);

  logic         main_valid_r;
  logic         skid_valid_r;
  qcsv_result_t main_r;
  qcsv_result_t skid_r;
  logic         push;
  logic         main_free;

  assign push_ready = !skid_valid_r;
  assign push       = push_valid && push_ready;
  assign main_free  = !main_valid_r || pop_ready;
  assign pop_valid  = main_valid_r;
  assign pop_data   = main_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      main_valid_r <= 1'b0;
      skid_valid_r <= 1'b0;
    end else if (main_free) begin
      if (skid_valid_r) begin
        main_valid_r <= 1'b1;
        skid_valid_r <= 1'b0;
      end else begin
        main_valid_r <= push;
      end
    end else if (push) begin
      skid_valid_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (main_free) begin
      if (skid_valid_r) begin
        main_r <= skid_r;
      end else if (push) begin
        main_r <= push_data;
      end
    end else if (push) begin
      skid_r <= push_data;
    end
  end

endmodule

// ===== hw/rtl/quoted_csv_field_splitter.sv =====
// Top level of the quoted CSV field splitter.
// Depends on qcsv_pkg, qcsv_if, qcsv_parser and qcsv_out_buf.
//
// Usage:
// The input channel carries one record byte per transfer (kind 0) and an end
// marker (kind 1) that closes the record. The output channel carries value
// bytes, field ends and record errors; at most one result follows each input
// transfer, and many transfers (opening quotes, swallowed bytes) give none.
// The field limit is written through cfg_we and cfg_wdata while the block is
// idle; it takes effect for the next transfer.
// Throughput is one input transfer per cycle while the output buffer has room.
// A result passes through the input register, where the parser state is
// updated, and then the result register, where it stays valid on the output
// until the receiver takes it.
// Reset clears the parser to the start of a record with no fields counted,
// sets the field limit to 32 and empties the input, result and skid registers.
// When the receiver stalls, a skid register absorbs one more result, then the
// input register holds its byte and input ready falls until results drain.
module quoted_csv_field_splitter
  import qcsv_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  qcsv_in_if.sink            in_ch,
  qcsv_out_if.source         out_ch,
  input  logic               cfg_we,
  input  logic [LIMIT_W-1:0] cfg_wdata
);

  qcsv_item_t   in_item;
  qcsv_result_t res;
  qcsv_result_t out_res;
  logic         res_valid;
  logic         res_ready;

  assign in_item.kind      = in_ch.kind;
  assign in_item.char_byte = in_ch.char_byte;

  qcsv_parser u_parser (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .in_item   (in_item),
    .res_ready (res_ready),
    .res_valid (res_valid),
    .res       (res)
  );

  qcsv_out_buf u_out_buf (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (res_valid),
    .push_ready (res_ready),
    .push_data  (res),
    .pop_valid  (out_ch.valid),
    .pop_ready  (out_ch.ready),
    .pop_data   (out_res)
  );

  assign out_ch.result_kind = out_res.result_kind;
  assign out_ch.value_byte  = out_res.value_byte;
  assign out_ch.field_index = out_res.field_index;
  assign out_ch.error_code  = out_res.error_code;
  assign out_ch.last        = out_res.last;

endmodule

// ===== test/tb_quoted_csv_field_splitter.sv =====
`timescale 1ns / 100ps
// Testbench for the quoted CSV field splitter: a directed table, then random records.
// Each field-limit setting has its own phase. Results are checked against typed table rows
// or a built-in parser model. Depends on qcsv_pkg, qcsv_if and quoted_csv_field_splitter.
module tb_quoted_csv_field_splitter;
  import qcsv_pkg::*;

  typedef enum logic [2:0] {
    PH_FIELD_START, PH_UNQUOTED, PH_QUOTED, PH_QUOTE_SEEN, PH_SWALLOW
  } split_phase_e;

  typedef enum logic [1:0] {ACT_NONE, ACT_VALUE, ACT_END, ACT_ERROR} split_act_e;

  typedef struct {
    logic       kind;
    logic [7:0] ch;
    bit         typed;
    bit         has_res;
    logic [1:0] rk;
    logic [7:0] val;
    logic [4:0] idx;
    logic [1:0] code;
    logic       last;
  } dir_row_t;

  localparam int PHASES = 8;
  localparam int PHASE_ITEMS = 200;

  logic clk = 1'b0;
  logic rst_n;
  logic cfg_we;
  logic [LIMIT_W-1:0] cfg_wdata;

  qcsv_in_if in_ch ();
  qcsv_out_if out_ch ();

  quoted_csv_field_splitter u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  split_phase_e       phase;
  int                 fields_done;
  logic [LIMIT_W-1:0] field_limit;

  qcsv_result_t pending_results [$];
  qcsv_item_t   record_bytes [$];

  int mismatches = 0;
  int items_sent = 0;
  int records_sent = 0;
  int limits_written = 0;
  int value_seen = 0;
  int ends_seen = 0;
  int errors_seen [4] = '{0, 0, 0, 0};
  int burst_left = 0;

  // Parser model: updates the split state for one accepted item and gives its result.
  function automatic bit split_byte(input logic kind, input logic [7:0] ch,
                                    output qcsv_result_t res);
    logic       at_end;
    int         lim;
    split_act_e act;
    logic [1:0] code;
    at_end = (kind == KIND_END);
    lim = (int'(field_limit) > MAX_FIELDS) ? MAX_FIELDS : int'(field_limit);
    res = '0;
    res.field_index = IDX_W'((fields_done > IDX_MAX) ? IDX_MAX : fields_done);
    act = ACT_NONE;
    code = ERR_TOO_MANY;
    case (phase)
      PH_FIELD_START: begin
        if (fields_done >= lim) begin
          act = ACT_ERROR;
          code = ERR_TOO_MANY;
        end else if (at_end || ch == COMMA_CH) begin
          act = ACT_END;
        end else if (ch == QUOTE_CH) begin
          phase = PH_QUOTED;
        end else begin
          phase = PH_UNQUOTED;
          act = ACT_VALUE;
        end
      end
      PH_UNQUOTED: begin
        if (at_end || ch == COMMA_CH) begin
          act = ACT_END;
        end else if (ch == QUOTE_CH) begin
          act = ACT_ERROR;
          code = ERR_STRAY_QT;
        end else begin
          act = ACT_VALUE;
        end
      end
      PH_QUOTED: begin
        if (at_end) begin
          act = ACT_ERROR;
          code = ERR_UNCLOSED;
        end else if (ch == QUOTE_CH) begin
          phase = PH_QUOTE_SEEN;
        end else begin
          act = ACT_VALUE;
        end
      end
      PH_QUOTE_SEEN: begin
        if (at_end || ch == COMMA_CH) begin
          act = ACT_END;
        end else if (ch == QUOTE_CH) begin
          phase = PH_QUOTED;
          act = ACT_VALUE;
        end else begin
          act = ACT_ERROR;
          code = ERR_JUNK_QT;
        end
      end
      default: begin
        if (at_end) begin
          phase = PH_FIELD_START;
          fields_done = 0;
        end
      end
    endcase
    case (act)
      ACT_VALUE: begin
        res.result_kind = RK_VALUE;
        res.value_byte = ch;
      end
      ACT_END: begin
        res.result_kind = RK_END;
        res.last = at_end;
        if (!at_end && fields_done < MAX_FIELDS) begin
          fields_done++;
        end else if (at_end) begin
          fields_done = 0;
        end
        phase = PH_FIELD_START;
      end
      ACT_ERROR: begin
        res.result_kind = RK_ERROR;
        res.error_code = code;
        res.last = 1'b1;
        if (at_end) begin
          phase = PH_FIELD_START;
          fields_done = 0;
        end else begin
          phase = PH_SWALLOW;
        end
      end
      default: ;
    endcase
    return act != ACT_NONE;
  endfunction

  task automatic report_mismatch(input string what, input int want, input int got);
    mismatches++;
    $display("%0t: mismatch on %s: expected %0d, got %0d", $realtime, what, want, got);
  endtask

  function automatic void expect_result(input qcsv_result_t res);
    pending_results.insert(pending_results.size(), res);
  endfunction

  function automatic void queue_item(input logic kind, input logic [7:0] b);
    qcsv_item_t it;
    it.kind = kind;
    it.char_byte = b;
    record_bytes.insert(record_bytes.size(), it);
  endfunction

  // Sends one item in bursts with random gaps and records what it should produce.
  task automatic send_item(input logic kind, input logic [7:0] ch, input bit use_typed,
                           input bit typed_has, input qcsv_result_t typed_res);
    int           gap;
    int           pick;
    bit           has;
    qcsv_result_t res;
    if (burst_left == 0) begin
      pick = $urandom_range(0, 9);
      burst_left = (pick == 0) ? 300 : $urandom_range(1, 16);
      gap = $urandom_range(1, 8);
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    burst_left--;
    in_ch.valid <= 1'b1;
    in_ch.kind <= kind;
    in_ch.char_byte <= ch;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    items_sent++;
    if (kind == KIND_END) records_sent++;
    has = split_byte(kind, ch, res);
    if (use_typed) begin
      has = typed_has;
      res = typed_res;
    end
    if (has) expect_result(res);
  endtask

  // Holds the sender until every expected result is back and the pipeline is empty.
  task automatic drain_results();
    in_ch.valid <= 1'b0;
    burst_left = 0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic set_field_limit(input logic [LIMIT_W-1:0] lim);
    drain_results();
    cfg_we <= 1'b1;
    cfg_wdata <= lim;
    @(posedge clk);
    field_limit = lim;
    limits_written++;
    cfg_we <= 1'b0;
  endtask

  function automatic logic [7:0] plain_byte();
    logic [7:0] b;
    do begin
      b = 8'($urandom_range(0, 255));
    end while (b == QUOTE_CH || b == COMMA_CH);
    return b;
  endfunction

  function automatic void push_char(input logic [7:0] b);
    queue_item(KIND_CHAR, b);
  endfunction

  function automatic void push_quoted_body(input int len);
    for (int i = 0; i < len; i++) begin
      if ($urandom_range(0, 4) == 0) begin
        push_char(QUOTE_CH);
        push_char(QUOTE_CH);
      end else begin
        logic [7:0] b;
        do begin
          b = 8'($urandom_range(0, 255));
        end while (b == QUOTE_CH);
        push_char(b);
      end
    end
  endfunction

  // Builds one record: mostly well-formed fields, some with one injected fault, some noise.
  function automatic void build_record(input int lim);
    int sel, nf, err_at, err_kind, len, pick;
    sel = $urandom_range(0, 99);
    if (sel < 15) begin
      len = $urandom_range(0, 10);
      for (int i = 0; i < len; i++) begin
        pick = $urandom_range(0, 3);
        push_char(pick == 0 ? QUOTE_CH : pick == 1 ? COMMA_CH : 8'($urandom_range(0, 255)));
      end
      queue_item(KIND_END, 8'($urandom_range(0, 255)));
      return;
    end
    pick = $urandom_range(0, 9);
    if (pick < 7) nf = $urandom_range(1, 5);
    else if (pick < 9) nf = lim + $urandom_range(0, 1);
    else nf = $urandom_range(20, 34);
    if (nf < 1) nf = 1;
    if (nf > 34) nf = 34;
    err_at = (sel < 35) ? $urandom_range(0, nf - 1) : -1;
    err_kind = $urandom_range(1, 3);
    for (int f = 0; f < nf; f++) begin
      if (f > 0) push_char(COMMA_CH);
      len = $urandom_range(0, 6);
      if (f == err_at) begin
        if (err_kind == 1) begin
          push_char(plain_byte());
          push_char(QUOTE_CH);
          for (int i = 0; i < len; i++) push_char(8'($urandom_range(0, 255)));
        end else if (err_kind == 2) begin
          push_char(QUOTE_CH);
          push_quoted_body(len);
          queue_item(KIND_END, 8'h00);
          return;
        end else begin
          push_char(QUOTE_CH);
          push_quoted_body(len);
          push_char(QUOTE_CH);
          push_char(plain_byte());
          for (int i = 0; i < len; i++) push_char(8'($urandom_range(0, 255)));
        end
      end else if ($urandom_range(0, 1) == 0) begin
        for (int i = 0; i < len; i++) push_char(plain_byte());
      end else begin
        push_char(QUOTE_CH);
        push_quoted_body(len);
        push_char(QUOTE_CH);
      end
    end
    queue_item(KIND_END, 8'h00);
  endfunction

  // The receiver switches among stall patterns that are picked at random as stall_cnt runs.
  int   stall_mode = 0;
  int   stall_cnt = 0;

  always @(posedge clk) begin
    stall_cnt <= stall_cnt + 1;
    if (stall_cnt % 128 == 127) stall_mode <= $urandom_range(0, 3);
    case (stall_mode)
      0: out_ch.ready <= 1'b1;
      1: out_ch.ready <= ($urandom_range(0, 3) != 0);
      2: out_ch.ready <= ($urandom_range(0, 3) == 0);
      default: out_ch.ready <= ((stall_cnt % 16) < 3);
    endcase
  end

  always @(posedge clk) begin : result_check
    qcsv_result_t want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      case (out_ch.result_kind)
        RK_VALUE: value_seen++;
        RK_END:   ends_seen++;
        RK_ERROR: errors_seen[out_ch.error_code]++;
        default:  ;
      endcase
      if (pending_results.size() == 0) begin
        report_mismatch("unexpected result kind", -1, out_ch.result_kind);
      end else begin
        want = pending_results.pop_front();
        if (out_ch.result_kind !== want.result_kind)
          report_mismatch("result_kind", want.result_kind, out_ch.result_kind);
        if (out_ch.value_byte !== want.value_byte)
          report_mismatch("value_byte", want.value_byte, out_ch.value_byte);
        if (out_ch.field_index !== want.field_index)
          report_mismatch("field_index", want.field_index, out_ch.field_index);
        if (out_ch.error_code !== want.error_code)
          report_mismatch("error_code", want.error_code, out_ch.error_code);
        if (out_ch.last !== want.last)
          report_mismatch("last", want.last, out_ch.last);
      end
    end
  end

  initial begin
    #5_000_000;
    $display("Simulation FAILED");
    $finish;
  end

  initial begin
    dir_row_t     dir_tab [23];
    int           limit_plan [PHASES];
    int           eff_limit;
    int           phase_start;
    qcsv_result_t typed;

    dir_tab = '{
      '{KIND_END,  8'h00,    1, 1, RK_END,   8'h00, 5'd0, ERR_TOO_MANY, 1'b1},
      '{KIND_CHAR, 8'h61,    1, 1, RK_VALUE, 8'h61, 5'd0, ERR_TOO_MANY, 1'b0},
      '{KIND_CHAR, COMMA_CH, 1, 1, RK_END,   8'h00, 5'd0, ERR_TOO_MANY, 1'b0},
      '{KIND_CHAR, QUOTE_CH, 1, 0, RK_VALUE, 8'h00, 5'd0, ERR_TOO_MANY, 1'b0},
      '{KIND_CHAR, COMMA_CH, 0, 0, RK_VALUE, 8'h00, 5'd0, ERR_TOO_MANY, 1'b0},
      '{KIND_CHAR, QUOTE_CH, 0, 0, RK_VALUE, 8'h00, 5'd0, ERR_TOO_MANY, 1'b0},
      '{KIND_CHAR, QUOTE_CH, 0, 0, RK_VALUE, 8'h00, 5'd0, ERR_TOO_MANY, 1'b0},
      '{KIND_CHAR, QUOTE_CH, 0, 0, RK_VALUE, 8'h00, 5'd0, ERR_TOO_MANY, 1'b0},
      '{KIND_END,  8'h00,    0, 0, RK_VALUE, 8'h00, 5'd0, ERR_TOO_MANY, 1'b0},
      '{KIND_CHAR, 8'h00,    1, 1, RK_VALUE, 8'h00, 5'd0, ERR_TOO_MANY, 1'b0},
      '{KIND_CHAR, 8'hFF,    1, 1, RK_VALUE, 8'hFF, 5'd0, ERR_TOO_MANY, 1'b0},
      '{KIND_CHAR, QUOTE_CH, 1, 1, RK_ERROR, 8'h00, 5'd0, ERR_STRAY_QT, 1'b1},
      '{KIND_CHAR, 8'h78,    1, 0, RK_VALUE, 8'h00, 5'd0, ERR_TOO_MANY, 1'b0},
      '{KIND_END,  8'hFF,    1, 0, RK_VALUE, 8'h00, 5'd0, ERR_TOO_MANY, 1'b0},
      '{KIND_CHAR, QUOTE_CH, 0, 0, RK_VALUE, 8'h00, 5'd0, ERR_TOO_MANY, 1'b0},
      '{KIND_CHAR, 8'h71,    0, 0, RK_VALUE, 8'h00, 5'd0, ERR_TOO_MANY, 1'b0},
      '{KIND_END,  8'h00,    1, 1, RK_ERROR, 8'h00, 5'd0, ERR_UNCLOSED, 1'b1},
      '{KIND_CHAR, QUOTE_CH, 0, 0, RK_VALUE, 8'h00, 5'd0, ERR_TOO_MANY, 1'b0},
      '{KIND_CHAR, QUOTE_CH, 0, 0, RK_VALUE, 8'h00, 5'd0, ERR_TOO_MANY, 1'b0},
      '{KIND_CHAR, 8'h7A,    1, 1, RK_ERROR, 8'h00, 5'd0, ERR_JUNK_QT,  1'b1},
      '{KIND_END,  8'h00,    1, 0, RK_VALUE, 8'h00, 5'd0, ERR_TOO_MANY, 1'b0},
      '{KIND_CHAR, COMMA_CH, 0, 0, RK_VALUE, 8'h00, 5'd0, ERR_TOO_MANY, 1'b0},
      '{KIND_END,  8'h00,    0, 0, RK_VALUE, 8'h00, 5'd0, ERR_TOO_MANY, 1'b0}
    };
    limit_plan = '{32, 1, 0, 63, 2, 33, 0, 0};
    limit_plan[6] = $urandom_range(1, 63);
    limit_plan[7] = $urandom_range(1, 63);

    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_wdata = '0;
    in_ch.valid = 1'b0;
    in_ch.kind = KIND_CHAR;
    in_ch.char_byte = 8'h00;
    out_ch.ready = 1'b0;
    phase = PH_FIELD_START;
    fields_done = 0;
    field_limit = FIELD_LIMIT_RESET;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (dir_tab[i]) begin
      typed = '0;
      typed.result_kind = dir_tab[i].rk;
      typed.value_byte = dir_tab[i].val;
      typed.field_index = dir_tab[i].idx;
      typed.error_code = dir_tab[i].code;
      typed.last = dir_tab[i].last;
      send_item(dir_tab[i].kind, dir_tab[i].ch, dir_tab[i].typed, dir_tab[i].has_res, typed);
    end

    for (int p = 0; p < PHASES; p++) begin
      set_field_limit(LIMIT_W'(limit_plan[p]));
      eff_limit = (limit_plan[p] > MAX_FIELDS) ? MAX_FIELDS : limit_plan[p];
      phase_start = items_sent;
      while (items_sent - phase_start < PHASE_ITEMS) begin
        build_record(eff_limit);
        while (record_bytes.size() != 0) begin
          qcsv_item_t it;
          it = record_bytes.pop_front();
          send_item(it.kind, it.char_byte, 1'b0, 1'b0, '0);
          if ($urandom_range(0, 299) == 0) drain_results();
        end
      end
    end

    drain_results();
    repeat (10) @(posedge clk);
    $display("Sent %0d transfers in %0d records under %0d field-limit writes.",
             items_sent, records_sent, limits_written);
    $display("Got %0d value bytes, %0d field ends, errors by code %0d/%0d/%0d/%0d.",
             value_seen, ends_seen, errors_seen[0], errors_seen[1], errors_seen[2],
             errors_seen[3]);
    if (mismatches == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
hw/rtl/qcsv_pkg.sv
hw/rtl/qcsv_if.sv
hw/rtl/qcsv_parser.sv
hw/rtl/qcsv_out_buf.sv
hw/rtl/quoted_csv_field_splitter.sv
test/tb_quoted_csv_field_splitter.sv
